@@ design/tsoe_pkg.sv @@
package tsoe_pkg;

  localparam int NUM_INSTRUMENTS_DEF = 16;
  localparam int WINDOW_DEF          = 10;
  localparam int PRICE_BITS_DEF      = 20;

  localparam int INST_W   = 4;
  localparam int LIMIT_W  = 20;
  localparam int OFFSET_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 2'd2;

  localparam logic [LIMIT_W-1:0]  BAND_LOW_RST  = 20'd10500;
  localparam logic [LIMIT_W-1:0]  BAND_HIGH_RST = 20'd19500;
  localparam logic [OFFSET_W-1:0] OFFSET_RST    = 10'd1;

  localparam int MIN_STAT_FILL = 5;
  localparam int MIN_RISE_FILL = 3;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture tick, read meta
    logic wr_win;   // write price to window, update meta
    logic acc;      // accumulate one window entry
    logic mul1;     // first product stage
    logic mul2;     // second product stage
    logic decide;   // form the result
  } tsoe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic inst_ok;
    logic acc_last;
  } tsoe_sts_t;

endpackage

@@ design/tick_signal_order_engine_core.sv @@
// Tick signal order engine.
// Input channel (in_valid/in_ready): one market tick, in_instrument and in_price.
// Output channel (out_valid/out_ready): exactly one result per tick, with the
// order fields and the four per-tick signal flags.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 band low,
// 1 band high, 2 order offset); other indexes are ignored. Write only when idle.
// Each accepted tick passes through the states write, accumulate, mul1, mul2
// and decide before out_valid; an instrument out of range goes from write
// straight to decide. The window accumulation reads one stored price a cycle
// and sums the window's n prices, n being its fill count once the new price
// is in (1 to WINDOW). One tick is processed at a time; the next is accepted
// the cycle after the result has been taken. Reset (rst_n low, synchronous)
// empties every window and restores the register defaults. When the receiver
// stalls, the result holds on the output and no new tick is accepted.
module tick_signal_order_engine_core
  import tsoe_pkg::*;
#(
  parameter int NUM_INSTRUMENTS = NUM_INSTRUMENTS_DEF,
  parameter int WINDOW          = WINDOW_DEF,
  parameter int PRICE_BITS      = PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INST_W-1:0]     in_instrument,
  input  logic [PRICE_BITS-1:0] in_price,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_order_valid,
  output logic                  out_order_is_buy,
  output logic [INST_W-1:0]     out_order_instrument,
  output logic [PRICE_BITS-1:0] out_order_price,
  output logic                  out_fired_band,
  output logic                  out_fired_mean_deviation,
  output logic                  out_fired_rising,
  output logic                  out_fired_volatility_dip,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0]  band_low_r, band_high_r;
  logic [OFFSET_W-1:0] offset_r;
  tsoe_cmd_t cmd;
  tsoe_sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r  <= BAND_LOW_RST;
      band_high_r <= BAND_HIGH_RST;
      offset_r    <= OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAND_LOW:  band_low_r  <= cfg_data[LIMIT_W-1:0];
        REG_BAND_HIGH: band_high_r <= cfg_data[LIMIT_W-1:0];
        REG_OFFSET:    offset_r    <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  tsoe_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  tsoe_dp #(
    .NUM_INSTRUMENTS(NUM_INSTRUMENTS), .WINDOW(WINDOW), .PRICE_BITS(PRICE_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_instrument, .in_price,
    .band_low(band_low_r), .band_high(band_high_r), .offset(offset_r),
    .out_order_valid, .out_order_is_buy, .out_order_instrument, .out_order_price,
    .out_fired_band, .out_fired_mean_deviation, .out_fired_rising,
    .out_fired_volatility_dip
  );

  // no new tick while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // an unaccepted result is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_order_price))
    else $error("result dropped");

  // is_buy only with an order
  a_buy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order_is_buy |-> out_order_valid) else $error("buy without order");

endmodule

@@ design/tsoe_ctrl.sv @@
module tsoe_ctrl
  import tsoe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tsoe_sts_t sts,
  output tsoe_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_ACC, S_MUL1, S_MUL2, S_DECIDE, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (sts.inst_ok) begin
          cmd.wr_win = 1'b1;
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.acc_last) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/tsoe_dp.sv @@
module tsoe_dp
  import tsoe_pkg::*;
#(
  parameter int NUM_INSTRUMENTS = NUM_INSTRUMENTS_DEF,
  parameter int WINDOW          = WINDOW_DEF,
  parameter int PRICE_BITS      = PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tsoe_cmd_t             cmd,
  output tsoe_sts_t             sts,
  input  logic [INST_W-1:0]     in_instrument,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic [LIMIT_W-1:0]    band_low,
  input  logic [LIMIT_W-1:0]    band_high,
  input  logic [OFFSET_W-1:0]   offset,
  output logic                  out_order_valid,
  output logic                  out_order_is_buy,
  output logic [INST_W-1:0]     out_order_instrument,
  output logic [PRICE_BITS-1:0] out_order_price,
  output logic                  out_fired_band,
  output logic                  out_fired_mean_deviation,
  output logic                  out_fired_rising,
  output logic                  out_fired_volatility_dip
);

  localparam int IW  = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int SW  = $clog2(WINDOW);         // slot index
  localparam int NW  = $clog2(WINDOW + 1);     // fill count
  localparam int DEPTH = NUM_INSTRUMENTS * WINDOW;
  localparam int AW  = $clog2(DEPTH);
  localparam int SUMW = PRICE_BITS + NW;
  localparam int SQW  = 2 * PRICE_BITS + NW;
  // comparison operand widths
  localparam int PNW  = PRICE_BITS + NW + 7;   // 100*p*n
  localparam int SCW  = SUMW + 7;              // 102*S
  localparam int LW   = SQW + NW + 12;         // 2500*n*Q
  localparam int RW   = 2 * SUMW + 12;         // 2501*S*S
  localparam int CW   = (LW > RW) ? LW : RW;
  localparam logic [SW-1:0] WLAST = SW'(WINDOW - 1);
  localparam logic [NW-1:0] NFULL = NW'(WINDOW);

  // window memory and ring metadata
  logic [PRICE_BITS-1:0] win_mem [DEPTH];
  logic [NW-1:0] fill_r   [NUM_INSTRUMENTS];
  logic [SW-1:0] oldest_r [NUM_INSTRUMENTS];

  logic [INST_W-1:0]     inst_r;
  logic [PRICE_BITS-1:0] price_r;
  logic                  inst_ok_r;
  logic [IW-1:0]         iidx;
  logic [NW-1:0]         n_r;
  logic [SW-1:0]         old_r;
  logic [SW-1:0]         rd_slot_r;
  logic [NW-1:0]         k_r;
  logic                  rd_vld_r;
  logic [PRICE_BITS-1:0] rd_data_r;
  logic [SUMW-1:0]       sum_r;
  logic [SQW-1:0]        sq_r;
  logic [PRICE_BITS-1:0] h0_r, h1_r, h2_r;  // last three prices
  logic [PNW-1:0]        pn_r;
  logic [PRICE_BITS+NW-1:0] pnb_r;
  logic [CW-1:0]         lhs_r, rhs_r;
  logic [2*SUMW-1:0]     ss_r;
  logic [SQW+NW-1:0]     nq_r;

  assign iidx = IW'(inst_r);

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] i, input logic [SW-1:0] s);
    addr_of = AW'(i) * AW'(WINDOW) + AW'(s);
  endfunction

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == WLAST) ? '0 : s + 1'b1;
  endfunction

  // slot of the new price: oldest + n modulo WINDOW while n is below WINDOW, else the oldest slot
  logic [SW:0] wr_sum;
  logic [SW-1:0] wr_slot;
  always_comb begin
    wr_sum = {1'b0, old_r} + (SW+1)'(n_r);
    if (n_r == NFULL) wr_slot = old_r;
    else if (wr_sum >= (SW+1)'(WINDOW)) wr_slot = SW'(wr_sum - (SW+1)'(WINDOW));
    else wr_slot = wr_sum[SW-1:0];
  end

  logic [NW-1:0] n_new;
  assign n_new = (n_r == NFULL) ? n_r : n_r + 1'b1;

  assign sts.inst_ok  = inst_ok_r;
  assign sts.acc_last = !rd_vld_r ? 1'b0 : (k_r == n_r) && !cmd.wr_win;

  // tick capture and ring update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_INSTRUMENTS; i++) begin
        fill_r[i]   <= '0;
        oldest_r[i] <= '0;
      end
    end else if (cmd.wr_win) begin
      fill_r[iidx] <= n_new;
      if (n_r == NFULL) oldest_r[iidx] <= slot_inc(old_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inst_r    <= in_instrument;
      price_r   <= in_price;
      inst_ok_r <= (32'(in_instrument) < NUM_INSTRUMENTS);
      n_r       <= fill_r[IW'(in_instrument)];
      old_r     <= oldest_r[IW'(in_instrument)];
    end
    if (cmd.wr_win) begin
      win_mem[addr_of(iidx, wr_slot)] <= price_r;
      n_r       <= n_new;
      rd_slot_r <= (n_r == NFULL) ? slot_inc(old_r) : old_r;
      old_r     <= (n_r == NFULL) ? slot_inc(old_r) : old_r;
      k_r       <= '0;
      sum_r     <= '0;
      sq_r      <= '0;
      rd_vld_r  <= 1'b0;
    end
    // read one entry a cycle, accumulate the previous one
    if (cmd.acc) begin
      rd_data_r <= win_mem[addr_of(iidx, rd_slot_r)];
      rd_slot_r <= slot_inc(rd_slot_r);
      rd_vld_r  <= 1'b1;
      if (rd_vld_r) begin
        sum_r <= sum_r + SUMW'(rd_data_r);
        sq_r  <= sq_r + SQW'(rd_data_r) * SQW'(rd_data_r);
        h2_r  <= h1_r;
        h1_r  <= h0_r;
        h0_r  <= rd_data_r;
      end
      k_r <= k_r + 1'b1;
    end
    // products, one multiply per path
    if (cmd.mul1) begin
      pnb_r <= (PRICE_BITS+NW)'(price_r) * (PRICE_BITS+NW)'(n_r);
      ss_r  <= sum_r * sum_r;
      nq_r  <= sq_r * n_r;
    end
    if (cmd.mul2) begin
      pn_r  <= PNW'(pnb_r) * PNW'(100);
      lhs_r <= CW'(nq_r) * CW'(2500);
      rhs_r <= CW'(ss_r) * CW'(2501);
    end
  end

  // the accumulate loop stops once k, the count of issued reads, equals n; the
  // final accumulation happens on that last step, which issues one unused read

  // decision
  logic band, dev, rise, dip, below, buy, sell;
  logic [PRICE_BITS:0] up;
  logic [PRICE_BITS-1:0] oprice;
  always_comb begin
    band  = (32'(price_r) < 32'(band_low)) || (32'(price_r) > 32'(band_high));
    below = (PNW'(pnb_r) < PNW'(sum_r));
    dev = 1'b0; dip = 1'b0; rise = 1'b0;
    if (n_r >= NW'(MIN_STAT_FILL)) begin
      dev = (pn_r < PNW'(SCW'(sum_r) * SCW'(98))) || (pn_r > PNW'(SCW'(sum_r) * SCW'(102)));
      dip = (pn_r < PNW'(SCW'(sum_r) * SCW'(99))) && (lhs_r > rhs_r);
    end
    if (n_r >= NW'(MIN_RISE_FILL)) rise = (h2_r < h1_r) && (h1_r < h0_r);
    if (!inst_ok_r) begin
      band = 1'b0; dev = 1'b0; dip = 1'b0; rise = 1'b0; below = 1'b0;
    end
    buy  = band || rise || dip || (dev && below);
    sell = dev && !below;
    up = {1'b0, price_r} + (PRICE_BITS+1)'(offset);
    oprice = '0;
    if (buy) oprice = up[PRICE_BITS] ? '1 : up[PRICE_BITS-1:0];
    else if (sell) oprice = (price_r >= PRICE_BITS'(offset)) ? price_r - PRICE_BITS'(offset) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_order_valid          <= buy || sell;
      out_order_is_buy         <= buy;
      out_order_instrument     <= inst_r;
      out_order_price          <= oprice;
      out_fired_band           <= band;
      out_fired_mean_deviation <= dev;
      out_fired_rising         <= rise;
      out_fired_volatility_dip <= dip;
    end
  end

endmodule
